// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/core/usd_pkg.sv =====
// Package with the types and constants of the unit separation direction block.
package usd_pkg;

    localparam int POS_WIDTH = 24;
    localparam int DIFF_W    = POS_WIDTH + 1;
    localparam int EXT_W     = 40;
    localparam int ABS_W     = 17;
    localparam int A2_W      = 2 * ABS_W;
    localparam int D2_W      = A2_W + 1;
    localparam int R_W       = 23;
    localparam int RR_W      = 2 * R_W;
    localparam int CMP_W     = D2_W + 12;
    localparam int REM_W     = D2_W + 1;
    localparam int Q_W       = 31;
    localparam int F_W       = 32;
    localparam int ROOT_W    = 16;
    localparam int SREM_W    = 19;
    localparam int NDIV      = Q_W;
    localparam int NSQ       = ROOT_W;
    localparam int FAR_LIMIT = 131072;
    localparam int SCALE_MUL = 125;
    localparam logic [15:0] ONE_Q14 = 16'd16384;

    localparam logic [1:0] CONTACT_NONE    = 2'd0;
    localparam logic [1:0] CONTACT_OVERLAP = 2'd1;
    localparam logic [1:0] CONTACT_COINC   = 2'd2;

    typedef struct packed {
        logic signed [POS_WIDTH-1:0] own_x;
        logic signed [POS_WIDTH-1:0] own_y;
        logic signed [POS_WIDTH-1:0] other_x;
        logic signed [POS_WIDTH-1:0] other_y;
        logic        [15:0]          other_scale;
    } req_t;

    typedef struct packed {
        logic signed [15:0] push_x;
        logic signed [15:0] push_y;
        logic        [1:0]  contact;
    } rsp_t;

    typedef struct packed {
        logic       nx;
        logic       ny;
        logic [1:0] contact;
    } side_t;

endpackage

// ===== rtl/core/usd_front.sv =====
// Front stages: difference, magnitude, squares, contact test.
module usd_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  usd_pkg::req_t               in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [usd_pkg::A2_W-1:0]    a2x,
    output logic [usd_pkg::A2_W-1:0]    a2y,
    output logic [usd_pkg::D2_W-1:0]    d2,
    output usd_pkg::side_t              side
);
    import usd_pkg::*;

    logic [4:0] v_reg;
    logic [5:0] rdy;

    logic [DIFF_W-1:0] dx0_reg, dy0_reg;
    logic [15:0]       s0_reg, s1_reg;
    logic [ABS_W-1:0]  ax1_reg, ay1_reg;
    logic              nx1_reg, ny1_reg, zero1_reg, far1_reg;
    logic [A2_W-1:0]   ax2_reg, ay2_reg, ax3_reg, ay3_reg, ax4_reg, ay4_reg;
    logic [R_W-1:0]    r2_reg;
    logic              nx2_reg, ny2_reg, zero2_reg, far2_reg;
    logic              nx3_reg, ny3_reg, zero3_reg, far3_reg;
    logic [D2_W-1:0]   d23_reg, d24_reg;
    logic [RR_W-1:0]   rr3_reg;
    side_t             side4_reg;

    logic [DIFF_W-1:0] dx_next, dy_next, ax_full, ay_full;
    logic [1:0]        contact_next;

    assign rdy[5] = out_ready;
    for (genvar k = 0; k < 5; k++) begin : g_rdy
        assign rdy[k] = !v_reg[k] || rdy[k+1];
    end
    assign in_ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v_reg <= '0;
        end else begin
            if (rdy[0]) v_reg[0] <= in_valid;
            for (int k = 1; k < 5; k++) begin
                if (rdy[k]) v_reg[k] <= v_reg[k-1];
            end
        end
    end

    assign dx_next = DIFF_W'(signed'(in_data.own_x)) - DIFF_W'(signed'(in_data.other_x));
    assign dy_next = DIFF_W'(signed'(in_data.own_y)) - DIFF_W'(signed'(in_data.other_y));
    assign ax_full = dx0_reg[DIFF_W-1] ? (DIFF_W'(0) - dx0_reg) : dx0_reg;
    assign ay_full = dy0_reg[DIFF_W-1] ? (DIFF_W'(0) - dy0_reg) : dy0_reg;

    always_comb begin
        if (zero3_reg) begin
            contact_next = CONTACT_COINC;
        end else if (far3_reg) begin
            contact_next = CONTACT_NONE;
        end else if ({d23_reg, 12'b0} < CMP_W'(rr3_reg)) begin
            contact_next = CONTACT_OVERLAP;
        end else begin
            contact_next = CONTACT_NONE;
        end
    end

    always_ff @(posedge clk) begin
        if (rdy[0]) begin
            dx0_reg <= dx_next;
            dy0_reg <= dy_next;
            s0_reg  <= in_data.other_scale;
        end
        if (rdy[1]) begin
            ax1_reg   <= ABS_W'(EXT_W'(ax_full));
            ay1_reg   <= ABS_W'(EXT_W'(ay_full));
            nx1_reg   <= dx0_reg[DIFF_W-1];
            ny1_reg   <= dy0_reg[DIFF_W-1];
            zero1_reg <= (dx0_reg == '0) && (dy0_reg == '0);
            far1_reg  <= (EXT_W'(ax_full) >= EXT_W'(FAR_LIMIT))
                      || (EXT_W'(ay_full) >= EXT_W'(FAR_LIMIT));
            s1_reg    <= s0_reg;
        end
        if (rdy[2]) begin
            ax2_reg   <= A2_W'(ax1_reg) * A2_W'(ax1_reg);
            ay2_reg   <= A2_W'(ay1_reg) * A2_W'(ay1_reg);
            r2_reg    <= R_W'(SCALE_MUL) * R_W'(s1_reg);
            nx2_reg   <= nx1_reg;
            ny2_reg   <= ny1_reg;
            zero2_reg <= zero1_reg;
            far2_reg  <= far1_reg;
        end
        if (rdy[3]) begin
            d23_reg   <= D2_W'(ax2_reg) + D2_W'(ay2_reg);
            rr3_reg   <= RR_W'(r2_reg) * RR_W'(r2_reg);
            ax3_reg   <= ax2_reg;
            ay3_reg   <= ay2_reg;
            nx3_reg   <= nx2_reg;
            ny3_reg   <= ny2_reg;
            zero3_reg <= zero2_reg;
            far3_reg  <= far2_reg;
        end
        if (rdy[4]) begin
            d24_reg           <= d23_reg;
            ax4_reg           <= ax3_reg;
            ay4_reg           <= ay3_reg;
            side4_reg.nx      <= nx3_reg;
            side4_reg.ny      <= ny3_reg;
            side4_reg.contact <= contact_next;
        end
    end

    assign out_valid = v_reg[4];
    assign a2x       = ax4_reg;
    assign a2y       = ay4_reg;
    assign d2        = d24_reg;
    assign side      = side4_reg;

endmodule

// ===== rtl/core/usd_div.sv =====
// Restoring divider pipeline, one quotient bit per stage, two lanes.
module usd_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [usd_pkg::A2_W-1:0]    a2x,
    input  logic [usd_pkg::A2_W-1:0]    a2y,
    input  logic [usd_pkg::D2_W-1:0]    d2,
    input  usd_pkg::side_t              in_side,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [usd_pkg::Q_W-1:0]     qx,
    output logic [usd_pkg::Q_W-1:0]     qy,
    output usd_pkg::side_t              out_side
);
    import usd_pkg::*;

    logic [NDIV-1:0]  v_reg;
    logic [NDIV:0]    rdy;
    logic [REM_W-1:0] rem_reg [NDIV][2];
    logic [Q_W-1:0]   q_reg   [NDIV][2];
    logic [D2_W-1:0]  d_reg   [NDIV];
    side_t            side_reg [NDIV];

    assign rdy[NDIV] = out_ready;
    assign in_ready  = rdy[0];

    for (genvar k = 0; k < NDIV; k++) begin : g_st
        logic [REM_W-1:0] rin   [2];
        logic [Q_W-1:0]   qin   [2];
        logic [REM_W-1:0] rnext [2];
        logic [Q_W-1:0]   qnext [2];
        logic [D2_W-1:0]  din;
        side_t            sin;
        logic             vin;

        assign rdy[k] = !v_reg[k] || rdy[k+1];

        if (k == 0) begin : g_first
            assign rin[0] = REM_W'(a2x);
            assign rin[1] = REM_W'(a2y);
            assign qin[0] = '0;
            assign qin[1] = '0;
            assign din    = d2;
            assign sin    = in_side;
            assign vin    = in_valid;
        end else begin : g_rest
            assign rin[0] = {rem_reg[k-1][0][REM_W-2:0], 1'b0};
            assign rin[1] = {rem_reg[k-1][1][REM_W-2:0], 1'b0};
            assign qin[0] = q_reg[k-1][0];
            assign qin[1] = q_reg[k-1][1];
            assign din    = d_reg[k-1];
            assign sin    = side_reg[k-1];
            assign vin    = v_reg[k-1];
        end

        always_comb begin
            for (int l = 0; l < 2; l++) begin
                if (rin[l] >= REM_W'(din)) begin
                    rnext[l] = rin[l] - REM_W'(din);
                    qnext[l] = {qin[l][Q_W-2:0], 1'b1};
                end else begin
                    rnext[l] = rin[l];
                    qnext[l] = {qin[l][Q_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                v_reg[k] <= 1'b0;
            end else if (rdy[k]) begin
                v_reg[k] <= vin;
            end
        end

        always_ff @(posedge clk) begin
            if (rdy[k]) begin
                rem_reg[k][0] <= rnext[0];
                rem_reg[k][1] <= rnext[1];
                q_reg[k][0]   <= qnext[0];
                q_reg[k][1]   <= qnext[1];
                d_reg[k]      <= din;
                side_reg[k]   <= sin;
            end
        end
    end

    assign out_valid = v_reg[NDIV-1];
    assign qx        = q_reg[NDIV-1][0];
    assign qy        = q_reg[NDIV-1][1];
    assign out_side  = side_reg[NDIV-1];

endmodule

// ===== rtl/core/usd_sqrt.sv =====
// Digit-by-digit integer square root pipeline, one root bit per stage, two lanes.
module usd_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [usd_pkg::Q_W-1:0]     qx,
    input  logic [usd_pkg::Q_W-1:0]     qy,
    input  usd_pkg::side_t              in_side,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [usd_pkg::ROOT_W-1:0]  rootx,
    output logic [usd_pkg::ROOT_W-1:0]  rooty,
    output usd_pkg::side_t              out_side
);
    import usd_pkg::*;

    logic [NSQ-1:0]    v_reg;
    logic [NSQ:0]      rdy;
    logic [SREM_W-1:0] rem_reg  [NSQ][2];
    logic [ROOT_W-1:0] root_reg [NSQ][2];
    logic [F_W-1:0]    f_reg    [NSQ][2];
    side_t             side_reg [NSQ];

    assign rdy[NSQ]  = out_ready;
    assign in_ready  = rdy[0];

    for (genvar k = 0; k < NSQ; k++) begin : g_st
        logic [SREM_W-1:0] rin   [2];
        logic [ROOT_W-1:0] tin   [2];
        logic [F_W-1:0]    fin   [2];
        logic [SREM_W-1:0] cur   [2];
        logic [SREM_W-1:0] trial [2];
        logic [SREM_W-1:0] rnext [2];
        logic [ROOT_W-1:0] tnext [2];
        side_t             sin;
        logic              vin;

        assign rdy[k] = !v_reg[k] || rdy[k+1];

        if (k == 0) begin : g_first
            assign rin[0] = '0;
            assign rin[1] = '0;
            assign tin[0] = '0;
            assign tin[1] = '0;
            assign fin[0] = F_W'(qx);
            assign fin[1] = F_W'(qy);
            assign sin    = in_side;
            assign vin    = in_valid;
        end else begin : g_rest
            assign rin[0] = rem_reg[k-1][0];
            assign rin[1] = rem_reg[k-1][1];
            assign tin[0] = root_reg[k-1][0];
            assign tin[1] = root_reg[k-1][1];
            assign fin[0] = f_reg[k-1][0];
            assign fin[1] = f_reg[k-1][1];
            assign sin    = side_reg[k-1];
            assign vin    = v_reg[k-1];
        end

        always_comb begin
            for (int l = 0; l < 2; l++) begin
                cur[l]   = {rin[l][SREM_W-3:0], fin[l][F_W-1-2*k -: 2]};
                trial[l] = {1'b0, tin[l], 2'b01};
                if (cur[l] >= trial[l]) begin
                    rnext[l] = cur[l] - trial[l];
                    tnext[l] = {tin[l][ROOT_W-2:0], 1'b1};
                end else begin
                    rnext[l] = cur[l];
                    tnext[l] = {tin[l][ROOT_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                v_reg[k] <= 1'b0;
            end else if (rdy[k]) begin
                v_reg[k] <= vin;
            end
        end

        always_ff @(posedge clk) begin
            if (rdy[k]) begin
                rem_reg[k][0]  <= rnext[0];
                rem_reg[k][1]  <= rnext[1];
                root_reg[k][0] <= tnext[0];
                root_reg[k][1] <= tnext[1];
                f_reg[k][0]    <= fin[0];
                f_reg[k][1]    <= fin[1];
                side_reg[k]    <= sin;
            end
        end
    end

    assign out_valid = v_reg[NSQ-1];
    assign rootx     = root_reg[NSQ-1][0];
    assign rooty     = root_reg[NSQ-1][1];
    assign out_side  = side_reg[NSQ-1];

endmodule

// ===== rtl/core/usd_out.sv =====
// Output stage: rounding, sign and result selection into the output register.
module usd_out (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [usd_pkg::ROOT_W-1:0]  rootx,
    input  logic [usd_pkg::ROOT_W-1:0]  rooty,
    input  usd_pkg::side_t              in_side,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output usd_pkg::rsp_t               rsp
);
    import usd_pkg::*;

    logic        v_reg;
    rsp_t        rsp_reg;
    rsp_t        rsp_next;
    logic [15:0] magx, magy;

    assign in_ready = !v_reg || rsp_ready;
    assign magx     = 16'((17'(rootx) + 17'd1) >> 1);
    assign magy     = 16'((17'(rooty) + 17'd1) >> 1);

    always_comb begin
        rsp_next.contact = in_side.contact;
        if (in_side.contact == CONTACT_COINC) begin
            rsp_next.push_x = ONE_Q14;
            rsp_next.push_y = ONE_Q14;
        end else if (in_side.contact == CONTACT_OVERLAP) begin
            rsp_next.push_x = in_side.nx ? (16'd0 - magx) : magx;
            rsp_next.push_y = in_side.ny ? (16'd0 - magy) : magy;
        end else begin
            rsp_next.push_x = '0;
            rsp_next.push_y = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (in_ready) begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = v_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== rtl/core/unit_separation_direction.sv =====
// Top level of the unit separation direction block.
// The block takes one transaction on the req channel: two unit positions and
// the scale of the other unit. It returns one transaction on the rsp channel:
// a Q2.14 separation direction and a contact code (none, overlap, coincident).
// Both channels use valid and ready; a transaction moves when both are high.
// An accepted request passes through five front stages, 31 divider stages,
// 16 square root stages and the output register before the response is
// valid. One request can be accepted every cycle while rsp_ready stays high,
// so the sustained throughput is then one transaction per cycle.
// Every stage carries its own valid bit and takes new data whenever it is
// empty or its successor moves, so bubbles close up while rsp_ready is low.
// When the receiver stalls, data stays in place and the pipeline keeps
// accepting requests until every stage holds one.
// Reset clears all valid bits; the block needs no warm-up after reset.
module unit_separation_direction (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  usd_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output usd_pkg::rsp_t  rsp
);
    import usd_pkg::*;

    logic              f_valid, f_ready;
    logic [A2_W-1:0]   f_a2x, f_a2y;
    logic [D2_W-1:0]   f_d2;
    side_t             f_side;
    logic              d_valid, d_ready;
    logic [Q_W-1:0]    d_qx, d_qy;
    side_t             d_side;
    logic              s_valid, s_ready;
    logic [ROOT_W-1:0] s_rootx, s_rooty;
    side_t             s_side;

    usd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req_valid),
        .in_ready  (req_ready),
        .in_data   (req),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .a2x       (f_a2x),
        .a2y       (f_a2y),
        .d2        (f_d2),
        .side      (f_side)
    );

    usd_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .a2x       (f_a2x),
        .a2y       (f_a2y),
        .d2        (f_d2),
        .in_side   (f_side),
        .out_valid (d_valid),
        .out_ready (d_ready),
        .qx        (d_qx),
        .qy        (d_qy),
        .out_side  (d_side)
    );

    usd_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d_valid),
        .in_ready  (d_ready),
        .qx        (d_qx),
        .qy        (d_qy),
        .in_side   (d_side),
        .out_valid (s_valid),
        .out_ready (s_ready),
        .rootx     (s_rootx),
        .rooty     (s_rooty),
        .out_side  (s_side)
    );

    usd_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .rootx     (s_rootx),
        .rooty     (s_rooty),
        .in_side   (s_side),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

// ===== rtl/core/usd_checker.sv =====
// Port-level checker for the unit separation direction block, with its bind.
`include "assert_macros.svh"

module usd_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_ready,
    input  usd_pkg::req_t  req,
    input  logic           rsp_valid,
    input  logic           rsp_ready,
    input  usd_pkg::rsp_t  rsp
);
    import usd_pkg::*;

    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))
    `ASSERT_IMPLY(a_coinc_dir, clk, rst_n, rsp_valid && (rsp.contact == CONTACT_COINC), (rsp.push_x == ONE_Q14) && (rsp.push_y == ONE_Q14))
    `ASSERT_IMPLY(a_none_zero, clk, rst_n, rsp_valid && (rsp.contact == CONTACT_NONE), (rsp.push_x == '0) && (rsp.push_y == '0))
    `ASSERT_IMPLY(a_overlap_range, clk, rst_n, rsp_valid && (rsp.contact == CONTACT_OVERLAP), (rsp.push_x <= 16'sd16384) && (rsp.push_x >= -16'sd16384) && (rsp.push_y <= 16'sd16384) && (rsp.push_y >= -16'sd16384))

endmodule

bind unit_separation_direction usd_checker u_usd_checker (.*);
